// ===== rtl/rtch_pkg.sv =====
`default_nettype none
package rtch_pkg;

    localparam int CB      = 20;
    localparam int EW      = 21;
    localparam int PW      = 43;
    localparam int DW      = 66;
    localparam int NW      = 108;
    localparam int FACE_W  = 10;
    localparam int Q_DEPTH = 4;
    localparam int QA_W    = 2;
    localparam logic [31:0] NO_HIT_DISTANCE = 32'd256000;

    typedef struct packed {
        logic signed [DW-1:0] det;
        logic signed [DW-1:0] un;
        logic signed [DW-1:0] vn;
        logic signed [DW-1:0] tn;
        logic                 last;
    } tri_job_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
        logic [16:0] u;
        logic [16:0] v;
        logic [FACE_W-1:0] face;
    } hit_res_t;

endpackage
`default_nettype wire

// ===== rtl/ray_triangle_closest_hit.sv =====
// from the accepting push edge to empty going low, a transaction passes the 3 front stages,
// the queue write, the take by an idle back end, the 33-step divide and the fold
// the back end divides bit-serially and takes no new transaction until it has done the fold;
// the back end takes no new transaction while a result transaction waits to be popped
// the front accepts while back end divides, until full: two queued, or one with the front busy
// reset: rst_n asynchronous active low clears the queue, run state and face counter
`default_nettype none
module ray_triangle_closest_hit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire logic [19:0] origin_x, origin_y, origin_z,
    input  wire logic [19:0] dir_x, dir_y, dir_z,
    input  wire logic [59:0] corner_a, corner_b, corner_c,
    input  wire logic last_face,
    output logic empty,
    input  wire logic pop,
    output logic hit,
    output logic [31:0] hit_distance,
    output logic [16:0] bary_u,
    output logic [16:0] bary_v,
    output logic [9:0] face_index
);
    // queue between the front (geometry) and back (divide and nearest fold)
    rtch_pkg::tri_job_t q_mem [rtch_pkg::Q_DEPTH];
    logic [rtch_pkg::QA_W-1:0] wp_reg, rp_reg;
    logic [rtch_pkg::QA_W:0] cnt_reg, inflight;
    logic f_valid, f_busy, b_take, b_busy, acc, res_v;
    rtch_pkg::tri_job_t f_job;
    rtch_pkg::hit_res_t r;

    // flag a transaction in the front pipe so the queue never overflows
    logic [1:0] pipe_cnt;
    assign pipe_cnt = 2'(f_busy ? 1 : 0);
    assign inflight = cnt_reg + 3'(pipe_cnt) + 3'(pipe_cnt);
    assign full = inflight >= 3'(rtch_pkg::Q_DEPTH - 1) && f_busy || cnt_reg >= 3'd2;
    assign acc  = push && !full;

    rtch_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(acc),
        .ox(origin_x), .oy(origin_y), .oz(origin_z),
        .dx(dir_x), .dy(dir_y), .dz(dir_z),
        .ca(corner_a), .cb(corner_b), .cc(corner_c), .last(last_face),
        .out_stall(1'b0), .busy(f_busy), .out_valid(f_valid), .out_job(f_job)
    );

    rtch_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(cnt_reg != '0), .job(q_mem[rp_reg]),
        .job_take(b_take), .res_valid(res_v), .res(r), .res_take(pop), .busy(b_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (f_valid) wp_reg <= wp_reg + 1'b1;
            if (b_take) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 3'(f_valid) - 3'(b_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_valid) q_mem[wp_reg] <= f_job;
    end

    // the result register of the back end is the output side of the block
    assign empty        = !res_v;
    assign hit          = r.hit;
    assign hit_distance = r.distance;
    assign bary_u       = r.u;
    assign bary_v       = r.v;
    assign face_index   = r.face;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(cnt_reg == 3'(rtch_pkg::Q_DEPTH) && f_valid))
        else $error("queue overflow");
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        b_take |-> cnt_reg != '0)
        else $error("back took from empty queue");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        b_take |-> !b_busy)
        else $error("back took a transaction while busy");
endmodule
`default_nettype wire

// ===== rtl/rtch_front.sv =====
`default_nettype none
module rtch_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic [rtch_pkg::CB-1:0] ox, oy, oz, dx, dy, dz,
    input  wire logic [59:0] ca, cb, cc,
    input  wire logic last,
    input  wire logic out_stall,
    output logic busy,
    output logic out_valid,
    output rtch_pkg::tri_job_t out_job
);
    // stage 1: edges, stage 2: cross products, stage 3: dots and sign fold
    logic s1_reg, s2_reg, s3_reg;
    logic l1_reg, l2_reg;
    logic signed [rtch_pkg::EW-1:0] e1_reg [3], e2_reg [3], tv_reg [3], d_reg [3];
    logic signed [rtch_pkg::PW-1:0] p_reg [3], q_reg [3];
    logic signed [rtch_pkg::EW-1:0] e1b_reg [3], e2b_reg [3], db_reg [3], tvb_reg [3];
    rtch_pkg::tri_job_t job_reg;

    logic signed [rtch_pkg::CB-1:0] a [3], b [3], c [3], o [3], d [3];
    logic signed [rtch_pkg::DW-1:0] det, un, vn, tn;

    assign busy = s1_reg | s2_reg | s3_reg;

    always_comb
    begin
        a[0] = ca[59:40]; a[1] = ca[39:20]; a[2] = ca[19:0];
        b[0] = cb[59:40]; b[1] = cb[39:20]; b[2] = cb[19:0];
        c[0] = cc[59:40]; c[1] = cc[39:20]; c[2] = cc[19:0];
        o[0] = ox; o[1] = oy; o[2] = oz;
        d[0] = dx; d[1] = dy; d[2] = dz;
        det = rtch_pkg::DW'(e1b_reg[0] * p_reg[0]) + rtch_pkg::DW'(e1b_reg[1] * p_reg[1])
            + rtch_pkg::DW'(e1b_reg[2] * p_reg[2]);
        un  = rtch_pkg::DW'(tvb_reg[0] * p_reg[0]) + rtch_pkg::DW'(tvb_reg[1] * p_reg[1])
            + rtch_pkg::DW'(tvb_reg[2] * p_reg[2]);
        vn  = rtch_pkg::DW'(db_reg[0] * q_reg[0]) + rtch_pkg::DW'(db_reg[1] * q_reg[1])
            + rtch_pkg::DW'(db_reg[2] * q_reg[2]);
        tn  = rtch_pkg::DW'(e2b_reg[0] * q_reg[0]) + rtch_pkg::DW'(e2b_reg[1] * q_reg[1])
            + rtch_pkg::DW'(e2b_reg[2] * q_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
            s3_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= in_valid;
            s2_reg <= s1_reg;
            if (!out_stall)
                s3_reg <= s2_reg;
            else if (s2_reg)
                s3_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= rtch_pkg::EW'(b[k]) - rtch_pkg::EW'(a[k]);
                e2_reg[k] <= rtch_pkg::EW'(c[k]) - rtch_pkg::EW'(a[k]);
                tv_reg[k] <= rtch_pkg::EW'(o[k]) - rtch_pkg::EW'(a[k]);
                d_reg[k]  <= rtch_pkg::EW'(d[k]);
            end
            l1_reg <= last;
        end
        if (s1_reg)
        begin
            p_reg[0] <= rtch_pkg::PW'(d_reg[1] * e2_reg[2]) - rtch_pkg::PW'(d_reg[2] * e2_reg[1]);
            p_reg[1] <= rtch_pkg::PW'(d_reg[2] * e2_reg[0]) - rtch_pkg::PW'(d_reg[0] * e2_reg[2]);
            p_reg[2] <= rtch_pkg::PW'(d_reg[0] * e2_reg[1]) - rtch_pkg::PW'(d_reg[1] * e2_reg[0]);
            q_reg[0] <= rtch_pkg::PW'(tv_reg[1] * e1_reg[2]) - rtch_pkg::PW'(tv_reg[2] * e1_reg[1]);
            q_reg[1] <= rtch_pkg::PW'(tv_reg[2] * e1_reg[0]) - rtch_pkg::PW'(tv_reg[0] * e1_reg[2]);
            q_reg[2] <= rtch_pkg::PW'(tv_reg[0] * e1_reg[1]) - rtch_pkg::PW'(tv_reg[1] * e1_reg[0]);
            e1b_reg <= e1_reg;
            e2b_reg <= e2_reg;
            db_reg  <= d_reg;
            tvb_reg <= tv_reg;
            l2_reg  <= l1_reg;
        end
        if (s2_reg)
        begin
            job_reg.last <= l2_reg;
            job_reg.det  <= det[rtch_pkg::DW-1] ? -det : det;
            job_reg.un   <= det[rtch_pkg::DW-1] ? -un : un;
            job_reg.vn   <= det[rtch_pkg::DW-1] ? -vn : vn;
            job_reg.tn   <= det[rtch_pkg::DW-1] ? -tn : tn;
        end
    end

    assign out_valid = s3_reg;
    assign out_job   = job_reg;
endmodule
`default_nettype wire

// ===== rtl/rtch_back.sv =====
`default_nettype none
module rtch_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  wire rtch_pkg::tri_job_t job,
    output logic job_take,
    output logic res_valid,
    output rtch_pkg::hit_res_t res,
    input  wire logic res_take,
    output logic busy
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;

    logic [1:0] state_reg;
    logic [5:0] cnt_reg;
    logic signed [rtch_pkg::DW-1:0] det_reg;
    logic [rtch_pkg::NW-1:0] rt_reg, ru_reg, rv_reg;
    logic [32:0] qt_reg, qu_reg, qv_reg;
    logic ok_reg, last_reg;
    logic have_reg;
    logic [31:0] bd_reg;
    logic [16:0] bu_reg, bv_reg;
    logic [rtch_pkg::FACE_W-1:0] bf_reg, fc_reg;
    logic res_v_reg;
    rtch_pkg::hit_res_t res_reg;

    logic ok;
    logic signed [rtch_pkg::DW:0] uv;
    logic [rtch_pkg::NW-1:0] dsh;
    logic [rtch_pkg::NW-1:0] tn_t, un_t, vn_t;
    logic [31:0] tsat;

    always_comb
    begin
        uv = {job.un[rtch_pkg::DW-1], job.un} + {job.vn[rtch_pkg::DW-1], job.vn};
        ok = (job.det != '0) && !job.un[rtch_pkg::DW-1] && (job.un <= job.det)
            && !job.vn[rtch_pkg::DW-1] && (uv <= {1'b0, job.det})
            && !job.tn[rtch_pkg::DW-1] && (job.tn != '0);
        dsh = rtch_pkg::NW'(det_reg) << (6'd32 - cnt_reg);
        tn_t = rt_reg - dsh;
        un_t = ru_reg - dsh;
        vn_t = rv_reg - dsh;
        tsat = qt_reg[32] ? 32'hFFFF_FFFF : qt_reg[31:0];
    end

    assign job_take  = (state_reg == ST_IDLE) && job_valid && !res_v_reg;
    assign busy      = state_reg != ST_IDLE;
    assign res_valid = res_v_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            have_reg  <= 1'b0;
            fc_reg    <= '0;
            res_v_reg <= 1'b0;
            bd_reg    <= '0;
            bu_reg    <= '0;
            bv_reg    <= '0;
            bf_reg    <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (res_v_reg && res_take)
                res_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_take)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                        last_reg  <= job.last;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    state_reg <= ST_IDLE;
                    if (ok_reg && (!have_reg || tsat < bd_reg))
                    begin
                        have_reg <= 1'b1;
                        bd_reg   <= tsat;
                        bu_reg   <= qu_reg[16:0];
                        bv_reg   <= qv_reg[16:0];
                        bf_reg   <= fc_reg;
                    end
                    fc_reg <= fc_reg + 1'b1;
                    if (last_reg)
                    begin
                        res_v_reg <= 1'b1;
                        have_reg  <= 1'b0;
                        fc_reg    <= '0;
                        bd_reg    <= '0;
                        bu_reg    <= '0;
                        bv_reg    <= '0;
                        bf_reg    <= '0;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            ok_reg  <= ok;
            det_reg <= job.det;
            rt_reg  <= rtch_pkg::NW'(job.tn) << 8;
            ru_reg  <= rtch_pkg::NW'(job.un) << 16;
            rv_reg  <= rtch_pkg::NW'(job.vn) << 16;
            qt_reg  <= '0;
            qu_reg  <= '0;
            qv_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            // restoring division, one quotient bit per cycle from bit 32 down
            qt_reg <= {qt_reg[31:0], !tn_t[rtch_pkg::NW-1]};
            qu_reg <= {qu_reg[31:0], !un_t[rtch_pkg::NW-1]};
            qv_reg <= {qv_reg[31:0], !vn_t[rtch_pkg::NW-1]};
            if (!tn_t[rtch_pkg::NW-1]) rt_reg <= tn_t;
            if (!un_t[rtch_pkg::NW-1]) ru_reg <= un_t;
            if (!vn_t[rtch_pkg::NW-1]) rv_reg <= vn_t;
        end
        if (state_reg == ST_FOLD && last_reg)
        begin
            if (ok_reg && (!have_reg || tsat < bd_reg))
            begin
                res_reg.hit      <= 1'b1;
                res_reg.distance <= tsat;
                res_reg.u        <= qu_reg[16:0];
                res_reg.v        <= qv_reg[16:0];
                res_reg.face     <= fc_reg;
            end
            else
            begin
                res_reg.hit      <= have_reg;
                res_reg.distance <= have_reg ? bd_reg : rtch_pkg::NO_HIT_DISTANCE;
                res_reg.u        <= have_reg ? bu_reg : '0;
                res_reg.v        <= have_reg ? bv_reg : '0;
                res_reg.face     <= have_reg ? bf_reg : '0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/ray_hit_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module ray_hit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [19:0] origin_x, origin_y, origin_z,
    input  wire logic [19:0] dir_x, dir_y, dir_z,
    input  wire logic [59:0] corner_a, corner_b, corner_c,
    input  wire logic        last_face,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic        hit,
    input  wire logic [31:0] hit_distance,
    input  wire logic [16:0] bary_u,
    input  wire logic [16:0] bary_v,
    input  wire logic [9:0]  face_index,
    output int               fails,
    output int               pending
);

    typedef logic signed [127:0] wide_t;

    rtch_pkg::hit_res_t                expected_hits[$];
    logic                              run_hit;
    logic [31:0]                       run_dist;
    logic [16:0]                       run_u;
    logic [16:0]                       run_v;
    logic [rtch_pkg::FACE_W-1:0]       run_best_face;
    logic [rtch_pkg::FACE_W-1:0]       run_face;

    function automatic longint sx(logic [19:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic wide_t dot3(input longint x[3], input longint y[3]);
        return wide_t'(x[0]) * wide_t'(y[0]) + wide_t'(x[1]) * wide_t'(y[1])
             + wide_t'(x[2]) * wide_t'(y[2]);
    endfunction

    task automatic cross3(input longint x[3], input longint y[3], output longint r[3]);
        r[0] = x[1] * y[2] - x[2] * y[1];
        r[1] = x[2] * y[0] - x[0] * y[2];
        r[2] = x[0] * y[1] - x[1] * y[0];
    endtask

    // floor of (num << sh) / den, saturated to 32 bits
    function automatic logic [31:0] qdiv(wide_t num, wide_t den, int sh);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        n = num;
        d = den;
        q = (n << sh) / d;
        if (q > 128'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return q[31:0];
    endfunction

    task automatic trace_triangle();
        longint   o[3], dv[3], a[3], b[3], c[3];
        longint   e1[3], e2[3], tv[3], pv[3], qv[3];
        wide_t    det, un, vn, tn;
        logic [31:0] tq;
        rtch_pkg::hit_res_t r;
        o[0] = sx(origin_x); o[1] = sx(origin_y); o[2] = sx(origin_z);
        dv[0] = sx(dir_x); dv[1] = sx(dir_y); dv[2] = sx(dir_z);
        a[0] = sx(corner_a[59:40]); a[1] = sx(corner_a[39:20]); a[2] = sx(corner_a[19:0]);
        b[0] = sx(corner_b[59:40]); b[1] = sx(corner_b[39:20]); b[2] = sx(corner_b[19:0]);
        c[0] = sx(corner_c[59:40]); c[1] = sx(corner_c[39:20]); c[2] = sx(corner_c[19:0]);
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = b[k] - a[k];
            e2[k] = c[k] - a[k];
            tv[k] = o[k] - a[k];
        end
        cross3(dv, e2, pv);
        cross3(tv, e1, qv);
        det = dot3(e1, pv);
        un  = dot3(tv, pv);
        vn  = dot3(dv, qv);
        tn  = dot3(e2, qv);
        if (det != 0)
        begin
            // fold the sign of the determinant into the numerators
            if (det < 0)
            begin
                det = -det;
                un  = -un;
                vn  = -vn;
                tn  = -tn;
            end
            if (un >= 0 && un <= det && vn >= 0 && un + vn <= det && tn > 0)
            begin
                tq = qdiv(tn, det, 8);
                // strict less-than: earlier face wins a tie
                if (!run_hit || tq < run_dist)
                begin
                    run_hit       = 1'b1;
                    run_dist      = tq;
                    run_u         = qdiv(un, det, 16);
                    run_v         = qdiv(vn, det, 16);
                    run_best_face = run_face;
                end
            end
        end
        run_face = run_face + 1'b1;
        if (last_face)
        begin
            r.hit      = run_hit;
            r.distance = run_hit ? run_dist : rtch_pkg::NO_HIT_DISTANCE;
            r.u        = run_hit ? run_u : '0;
            r.v        = run_hit ? run_v : '0;
            r.face     = run_hit ? run_best_face : '0;
            expected_hits = {expected_hits, r};
            run_hit       = 1'b0;
            run_dist      = '0;
            run_u         = '0;
            run_v         = '0;
            run_best_face = '0;
            run_face      = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_hits.delete();
            run_hit       = 1'b0;
            run_dist      = '0;
            run_u         = '0;
            run_v         = '0;
            run_best_face = '0;
            run_face      = '0;
            fails         = 0;
            pending       = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_hits.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transaction: %0d %0d %0d %0d %0d",
                                 hit, hit_distance, bary_u, bary_v, face_index);
                end
                else
                begin
                    rtch_pkg::hit_res_t e;
                    e = expected_hits.pop_front();
                    if (e.hit !== hit || e.distance !== hit_distance || e.u !== bary_u ||
                        e.v !== bary_v || e.face !== face_index)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch: exp hit=%0d t=%0d u=%0d v=%0d face=%0d",
                                     e.hit, e.distance, e.u, e.v, e.face);
                            $display("          got hit=%0d t=%0d u=%0d v=%0d face=%0d",
                                     hit, hit_distance, bary_u, bary_v, face_index);
                        end
                    end
                end
            end
            if (push && !full)
                trace_triangle();
            pending = expected_hits.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_ray_triangle_closest_hit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_ray_triangle_closest_hit;

    typedef longint v3_t [3];

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [19:0] origin_x, origin_y, origin_z;
    logic [19:0] dir_x, dir_y, dir_z;
    logic [59:0] corner_a, corner_b, corner_c;
    logic        last_face;
    logic        empty;
    logic        pop;
    logic        hit;
    logic [31:0] hit_distance;
    logic [16:0] bary_u;
    logic [16:0] bary_v;
    logic [9:0]  face_index;
    int          fails;
    int          pending;

    // sender bookkeeping
    int          items_sent;
    v3_t         prev_a, prev_b, prev_c, prev_o, prev_d;

    ray_triangle_closest_hit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .last_face(last_face), .empty(empty), .pop(pop), .hit(hit),
        .hit_distance(hit_distance), .bary_u(bary_u), .bary_v(bary_v),
        .face_index(face_index)
    );

    // predicts every run and compares each result transaction
    ray_hit_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .last_face(last_face), .empty(empty), .pop(pop), .hit(hit),
        .hit_distance(hit_distance), .bary_u(bary_u), .bary_v(bary_v),
        .face_index(face_index), .fails(fails), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #(12 * 1200000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [59:0] pk(input v3_t v);
        return {v[0][19:0], v[1][19:0], v[2][19:0]};
    endfunction

    function automatic logic [59:0] rnd60();
        return 60'({$urandom(), $urandom()});
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offers one transaction and holds it until accepted; optional idle gap first
    task automatic offer_raw(input logic [19:0] ox, oy, oz, dx, dy, dz,
                             input logic [59:0] ca, cb, cc, input logic lst, input bit idle);
        int gap;
        gap = idle ? sender_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      <= 1'b1;
        origin_x  <= ox; origin_y <= oy; origin_z <= oz;
        dir_x     <= dx; dir_y <= dy; dir_z <= dz;
        corner_a  <= ca; corner_b <= cb; corner_c <= cc;
        last_face <= lst;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
            @(negedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    task automatic offer_tri(input v3_t o, input v3_t d, input v3_t a, input v3_t b,
                             input v3_t c, input logic lst, input bit idle);
        prev_o = o; prev_d = d; prev_a = a; prev_b = b; prev_c = c;
        offer_raw(o[0][19:0], o[1][19:0], o[2][19:0], d[0][19:0], d[1][19:0], d[2][19:0],
                  pk(a), pk(b), pk(c), lst, idle);
    endtask

    // well-formed case: the ray passes near the centroid of the triangle
    // kind 0 hit, 1 ray pointing away, 2 degenerate triangle
    task automatic offer_aimed(input int kind, input logic lst, input bit idle);
        v3_t o, d, p, r1, r2, a, b, c;
        int  t;
        t = $urandom_range(1, 16);
        for (int k = 0; k < 3; k++)
        begin
            o[k]  = longint'($urandom_range(0, 120000)) - 60000;
            d[k]  = longint'($urandom_range(0, 6000)) - 3000;
            p[k]  = o[k] + t * d[k];
            r1[k] = longint'($urandom_range(0, 40000)) - 20000;
            r2[k] = longint'($urandom_range(0, 40000)) - 20000;
            a[k]  = p[k] + r1[k];
            b[k]  = p[k] + r2[k];
            c[k]  = p[k] - r1[k] - r2[k] + longint'($urandom_range(0, 4000)) - 2000;
            if (kind == 1)
                d[k] = -d[k];
        end
        if (kind == 2)
            c = b;
        offer_tri(o, d, a, b, c, lst, idle);
    endtask

    task automatic offer_noise(input logic lst, input bit idle);
        offer_raw(20'($urandom()), 20'($urandom()), 20'($urandom()),
                  20'($urandom()), 20'($urandom()), 20'($urandom()),
                  rnd60(), rnd60(), rnd60(), lst, idle);
    endtask

    // one triangle inside a random run
    task automatic offer_mixed(input logic lst, input int hit_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < hit_pct)
            offer_aimed(0, lst, 1'b1);
        else if (r < hit_pct + 8)
            offer_tri(prev_o, prev_d, prev_a, prev_b, prev_c, lst, 1'b1); // tie repeat
        else if (r < hit_pct + 16)
            offer_aimed($urandom_range(1, 2), lst, 1'b1);
        else
            offer_noise(lst, 1'b1);
    endtask

    // receiver: random stalls plus one long hold-off so the block backs up
    initial
    begin
        int cyc;
        int n;
        int r;
        bit held;
        pop  = 1'b0;
        cyc  = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (!held && cyc > 3000)
            begin
                held = 1'b1;
                pop <= 1'b0;
                n = 2500;
            end
            else if (r < 55)
            begin
                pop <= 1'b1;
                n = $urandom_range(1, 20);
            end
            else
            begin
                pop <= 1'b0;
                n = (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 80);
            end
            repeat (n) @(negedge clk);
            cyc += n;
        end
    end

    initial
    begin
        v3_t o, d, a, b, c;
        int  len;
        int  wait_cyc;
        bit  long_done;
        rst_n      = 1'b0;
        push       = 1'b0;
        origin_x   = '0; origin_y = '0; origin_z = '0;
        dir_x      = '0; dir_y = '0; dir_z = '0;
        corner_a   = '0; corner_b = '0; corner_c = '0;
        last_face  = 1'b0;
        items_sent = 0;
        long_done  = 1'b0;
        prev_o = '{0, 0, 0}; prev_d = '{0, 0, 0};
        prev_a = '{0, 0, 0}; prev_b = '{0, 0, 0}; prev_c = '{0, 0, 0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // all-zero fields: zero determinant
        offer_raw('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0);
        // all-ones fields
        offer_raw('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1, 1'b0);
        // coordinate extremes
        offer_raw(20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000,
                  {20'h80000, 20'h80000, 20'h7FFFF}, {20'h7FFFF, 20'h80000, 20'h80000},
                  {20'h80000, 20'h7FFFF, 20'h80000}, 1'b1, 1'b0);
        // clean hit at t = 1 on the z = 0 plane
        o = '{64, 64, -256}; d = '{0, 0, 256};
        a = '{0, 0, 0}; b = '{1024, 0, 0}; c = '{0, 1024, 0};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        // ray pointing away from the plane
        d = '{0, 0, -256};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        // origin on the plane: t = 0 rejected
        o = '{64, 64, 0}; d = '{0, 0, 256};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        // through corner a (u = v = 0), corner b (u = 1), corner c (v = 1)
        o = '{0, 0, -512};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        o = '{1024, 0, -512};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        o = '{0, 1024, -512};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        // on the u + v = 1 edge, then just outside it
        o = '{512, 512, -512};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        o = '{513, 512, -512};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        // equal distances: the earlier face of the run wins
        o = '{100, 100, -256};
        offer_tri(o, d, a, b, c, 1'b0, 1'b0);
        offer_tri(o, d, a, b, c, 1'b0, 1'b0);
        // nearer face after a miss, then a farther one
        offer_aimed(2, 1'b0, 1'b0);
        a = '{0, 0, -128}; b = '{1024, 0, -128}; c = '{0, 1024, -128};
        offer_tri(o, d, a, b, c, 1'b0, 1'b0);
        a = '{0, 0, 300}; b = '{1024, 0, 300}; c = '{0, 1024, 300};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        // two close distances that round to different values, the nearer face first
        d = '{0, 0, 3};
        a = '{0, 0, 1}; b = '{1024, 0, 1}; c = '{0, 1024, 1};
        o = '{100, 100, 0};
        offer_tri(o, d, a, b, c, 1'b0, 1'b0);
        a = '{0, 0, 1}; b = '{1024, 0, 1}; c = '{0, 1024, 2};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);
        // huge distance attempt: ray almost parallel to the plane
        o = '{0, 0, -128}; d = '{262143, 0, 1};
        a = '{0, -262143, 0}; b = '{0, 262143, 0}; c = '{262144, 0, 1};
        offer_tri(o, d, a, b, c, 1'b1, 1'b0);

        // random runs: mostly short, a few long, one past the face counter wrap
        while (items_sent < 1950)
        begin
            if (!long_done && items_sent > 600)
            begin
                long_done = 1'b1;
                len = 1030;
            end
            else if ($urandom_range(0, 99) < 90)
                len = $urandom_range(1, 6);
            else
                len = $urandom_range(15, 60);
            for (int i = 0; i < len; i++)
                offer_mixed(i == len - 1, (len > 100) ? 5 : 65);
        end
        push <= 1'b0;

        wait_cyc = 0;
        while (pending != 0 && wait_cyc < 200000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (80) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rtch_pkg.sv
rtl/rtch_front.sv
rtl/rtch_back.sv
rtl/ray_triangle_closest_hit.sv
tb/ray_hit_checker.sv
tb/tb_ray_triangle_closest_hit.sv
